// ----- rtl/nva_pkg.sv -----
// nva_pkg: shared constants, codes and the frequency-number table of the voice allocator
// used by nva_voice_table and note_voice_allocator; no dependencies
`default_nettype none

package nva_pkg;

    // default number of voices in the table
    localparam int NVA_VOICES = 18;

    // reset value of the voice count register
    localparam logic [4:0] VC_RESET = 5'd18;

    // event kinds
    localparam logic FUNC_ON  = 1'b0;
    localparam logic FUNC_OFF = 1'b1;

    // playable note range and octave size
    localparam logic [6:0] NOTE_BASE = 7'd19;
    localparam logic [6:0] NOTE_TOP  = 7'd114;
    localparam logic [6:0] SEMIS     = 7'd12;

    // channel numbers per register array
    localparam logic [3:0] CHN_LAST = 4'd8;

    // chip register addresses and bits
    localparam logic [7:0] ADDR_FNUM_LO = 8'hA0;
    localparam logic [7:0] ADDR_KEY     = 8'hB0;
    localparam logic [7:0] KEY_ON_BIT   = 8'h20;
    localparam logic [7:0] KEY_OFF_DATA = 8'h00;

    // 10-bit frequency number for each semitone of an octave
    function automatic logic [9:0] fnum_lookup(input logic [3:0] semi);
        logic [9:0] f;
        begin
            case (semi)
                4'd0:    f = 10'd517;
                4'd1:    f = 10'd547;
                4'd2:    f = 10'd580;
                4'd3:    f = 10'd615;
                4'd4:    f = 10'd651;
                4'd5:    f = 10'd690;
                4'd6:    f = 10'd731;
                4'd7:    f = 10'd774;
                4'd8:    f = 10'd820;
                4'd9:    f = 10'd869;
                4'd10:   f = 10'd921;
                4'd11:   f = 10'd975;
                default: f = 10'd0;
            endcase
            return f;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/nva_voice_table.sv -----
// nva_voice_table: note held by each voice, one write and one registered read per cycle
// depends on nva_pkg
`default_nettype none

module nva_voice_table
    import nva_pkg::*;
#(
    parameter int VOICES = NVA_VOICES,
    parameter int IDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output logic      [6:0]       rd_data,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire logic [6:0]       wr_data
);

    logic [6:0]        mem [VOICES];
    logic [VOICES-1:0] written_reg;
    logic [6:0]        rd_data_reg;
    logic              rd_written_reg;

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // per-voice written marks, a voice never written reads as free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_written_reg ? rd_data_reg : 7'd0;

endmodule

`default_nettype wire

// ----- rtl/note_voice_allocator.sv -----
// note_voice_allocator: top level, event sequencer, voice scan and register-write output
// depends on nva_pkg and nva_voice_table
//
// Takes note-on / note-off events and turns them into FM chip register writes. A table
// holds the note each voice plays (0 = free). Note-on takes the lowest free voice below
// min(voice_count, VOICES) and produces two transfers: the frequency low byte at 0xA0 + ch,
// then key-on at 0xB0 + ch with block and frequency high bits. Note-off frees the lowest
// voice holding the note and produces one key-off transfer at 0xB0 + ch. Notes outside
// 19..114, a full table or a note not held produce no transfer. The block takes one event
// at a time and holds in_stall high until its last write has been taken. Each event is
// taken in the idle state; then the table scan reads one voice per cycle through the table's
// single read port and compares it in the following cycle; then the load state readies the
// first write; then the output transfers follow, each held while out_stall is high. The
// octave split of note-on starts with the scan on a shared subtract-by-12 unit (at most 7
// steps), so a hit in one of the first five voices keeps the load stage waiting until the
// split is done. voice_count may only be written while the block is idle.
`default_nettype none

module note_voice_allocator
    import nva_pkg::*;
#(
    parameter int VOICES = NVA_VOICES
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // configuration
    input  wire logic       cfg_we,
    input  wire logic [4:0] cfg_wdata,
    // event input
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       func,
    input  wire logic [6:0] note,
    // register-write output
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            reg_bank,
    output logic      [7:0] reg_addr,
    output logic      [7:0] reg_data,
    output logic      [4:0] voice,
    output logic            last
);

    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CNT_W = $clog2(VOICES + 1);
    localparam int CW    = (CNT_W > 5) ? CNT_W : 5;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_OUT1 = 3'd3;
    localparam logic [2:0] S_OUT2 = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [4:0]       voice_count_reg;
    logic             func_reg, func_next;
    logic [6:0]       note_reg, note_next;

    // shared subtract-by-12 unit: remainder and octave block
    logic [6:0]       rem_reg, rem_next;
    logic [2:0]       blk_reg, blk_next;

    // scan issue side
    logic [CW-1:0]    idx_reg, idx_next;
    logic [3:0]       chn_reg, chn_next;
    logic             bank_reg, bank_next;

    // scan compare side, in step with the registered table read
    logic             cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [3:0]       cmp_chn_reg, cmp_chn_next;
    logic             cmp_bank_reg, cmp_bank_next;

    // voice that was hit
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [3:0]       hit_chn_reg, hit_chn_next;
    logic             hit_bank_reg, hit_bank_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_addr_reg, out_addr_next;
    logic [7:0]       out_data_reg, out_data_next;
    logic             last_reg, last_next;

    logic [CW-1:0]    vc_ext;
    logic [CW-1:0]    act_cnt;
    logic             in_xfer;
    logic             out_xfer;
    logic             note_ok;
    logic             issue;
    logic             match;
    logic             rem_done;
    logic [6:0]       entry;
    logic [9:0]       fnum;
    logic             tbl_we;
    logic [6:0]       tbl_wdata;
    logic [IDX_W+4:0] hit_idx_wide;

    // active voices: voice_count limited to VOICES
    assign vc_ext  = CW'(voice_count_reg);
    assign act_cnt = (vc_ext > CW'(VOICES)) ? CW'(VOICES) : vc_ext;

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign note_ok  = (note >= NOTE_BASE) && (note <= NOTE_TOP) && (act_cnt != '0);

    assign issue    = (state_reg == S_SCAN) && (idx_reg < act_cnt) && !match;
    assign match    = cmp_vld_reg &&
                      ((func_reg == FUNC_OFF) ? (entry == note_reg) : (entry == 7'd0));
    assign rem_done = (rem_reg < SEMIS);
    assign fnum     = fnum_lookup(rem_reg[3:0]);

    assign tbl_we    = (state_reg == S_SCAN) && match;
    assign tbl_wdata = (func_reg == FUNC_OFF) ? 7'd0 : note_reg;

    nva_voice_table #(
        .VOICES (VOICES),
        .IDX_W  (IDX_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (issue),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (entry),
        .wr_en   (tbl_we),
        .wr_addr (cmp_idx_reg),
        .wr_data (tbl_wdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        note_next      = note_reg;
        rem_next       = rem_reg;
        blk_next       = blk_reg;
        idx_next       = idx_reg;
        chn_next       = chn_reg;
        bank_next      = bank_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = idx_reg[IDX_W-1:0];
        cmp_chn_next   = chn_reg;
        cmp_bank_next  = bank_reg;
        hit_idx_next   = hit_idx_reg;
        hit_chn_next   = hit_chn_reg;
        hit_bank_next  = hit_bank_reg;
        out_valid_next = out_valid_reg;
        out_addr_next  = out_addr_reg;
        out_data_next  = out_data_reg;
        last_next      = last_reg;

        // octave split, one subtraction per cycle until below 12
        if (state_reg != S_IDLE && !rem_done)
        begin
            rem_next = rem_reg - SEMIS;
            blk_next = blk_reg + 3'd1;
        end

        // channel and bank follow the issued voice index
        if (issue)
        begin
            cmp_vld_next = 1'b1;
            idx_next     = CW'(idx_reg + 1'b1);
            if (chn_reg == CHN_LAST)
            begin
                chn_next  = 4'd0;
                bank_next = !bank_reg;
            end
            else
            begin
                chn_next = chn_reg + 4'd1;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && note_ok)
                begin
                    func_next  = func;
                    note_next  = note;
                    rem_next   = note - NOTE_BASE;
                    blk_next   = 3'd0;
                    idx_next   = '0;
                    chn_next   = 4'd0;
                    bank_next  = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (match)
                begin
                    hit_idx_next  = cmp_idx_reg;
                    hit_chn_next  = cmp_chn_reg;
                    hit_bank_next = cmp_bank_reg;
                    state_next    = S_FIN;
                end
                else if (!cmp_vld_reg && !issue)
                begin
                    // scan ran out: no free voice or note not held
                    state_next = S_IDLE;
                end
            end
            S_FIN:
            begin
                if (func_reg == FUNC_OFF)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = ADDR_KEY + {4'd0, hit_chn_reg};
                    out_data_next  = KEY_OFF_DATA;
                    last_next      = 1'b1;
                    state_next     = S_OUT2;
                end
                else if (rem_done)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = ADDR_FNUM_LO + {4'd0, hit_chn_reg};
                    out_data_next  = fnum[7:0];
                    last_next      = 1'b0;
                    state_next     = S_OUT1;
                end
            end
            S_OUT1:
            begin
                if (out_xfer)
                begin
                    out_addr_next = ADDR_KEY + {4'd0, hit_chn_reg};
                    out_data_next = KEY_ON_BIT | {3'd0, blk_reg, fnum[9:8]};
                    last_next     = 1'b1;
                    state_next    = S_OUT2;
                end
            end
            S_OUT2:
            begin
                if (out_xfer)
                begin
                    out_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
                state_next     = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            voice_count_reg <= VC_RESET;
            cmp_vld_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_vld_reg   <= cmp_vld_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                voice_count_reg <= cfg_wdata;
            end
        end
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        note_reg     <= note_next;
        rem_reg      <= rem_next;
        blk_reg      <= blk_next;
        idx_reg      <= idx_next;
        chn_reg      <= chn_next;
        bank_reg     <= bank_next;
        cmp_idx_reg  <= cmp_idx_next;
        cmp_chn_reg  <= cmp_chn_next;
        cmp_bank_reg <= cmp_bank_next;
        hit_idx_reg  <= hit_idx_next;
        hit_chn_reg  <= hit_chn_next;
        hit_bank_reg <= hit_bank_next;
        out_addr_reg <= out_addr_next;
        out_data_reg <= out_data_next;
        last_reg     <= last_next;
    end

    // voice index trimmed to the 5-bit field
    assign hit_idx_wide = {5'd0, hit_idx_reg};

    assign out_valid = out_valid_reg;
    assign reg_bank  = hit_bank_reg;
    assign reg_addr  = out_addr_reg;
    assign reg_data  = out_data_reg;
    assign voice     = hit_idx_wide[4:0];
    assign last      = last_reg;

    // a result only stands while the sequencer is in an output state
    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == S_OUT1 || state_reg == S_OUT2))
        else $error("result valid outside an output state");

    // a new event is never taken while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid)
        else $error("input taken while a result is pending");

    // the frequency write is always followed by the key-on write
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=> (out_valid && last))
        else $error("key-on write missing after frequency write");

    // the octave split is finished before the first write is shown
    a_split_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT1) |-> (rem_reg < SEMIS))
        else $error("semitone out of range at output");

endmodule

`default_nettype wire

// ----- test/nva_write_checker.sv -----
`timescale 1ns / 1ps
// nva_write_checker: watches the event and register-write channels of note_voice_allocator,
// keeps its own voice table and compares every chip write with the predicted one
// depends on nva_pkg only
module nva_write_checker
    import nva_pkg::*;
#(
    parameter int VOICES = NVA_VOICES
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [4:0] cfg_wdata,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic       func,
    input  wire logic [6:0] note,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic       reg_bank,
    input  wire logic [7:0] reg_addr,
    input  wire logic [7:0] reg_data,
    input  wire logic [4:0] voice,
    input  wire logic       last,
    output int              mismatch_count,
    output int              writes_pending
);

    typedef struct packed {
        logic       bank;
        logic [7:0] addr;
        logic [7:0] data;
        logic [4:0] voice;
        logic       last;
    } chip_write_t;

    // frequency number per semitone, semitone 0 in the low slot
    localparam logic [11:0][9:0] FNUM_OF_SEMI = {
        10'd975, 10'd921, 10'd869, 10'd820, 10'd774, 10'd731,
        10'd690, 10'd651, 10'd615, 10'd580, 10'd547, 10'd517
    };

    logic [6:0]  voice_note [VOICES];
    logic [4:0]  voice_limit;
    chip_write_t writes_due [$];
    chip_write_t seen;

    function automatic chip_write_t chip_write(input int v, input logic [7:0] addr,
                                               input logic [7:0] data, input logic is_last);
        chip_write_t w;
        begin
            w.bank  = ((v / 9) % 2) != 0;
            w.addr  = addr;
            w.data  = data;
            w.voice = v[4:0];
            w.last  = is_last;
            return w;
        end
    endfunction

    // allocate or free a voice for one event and queue the writes it causes
    task automatic play_event(input logic ev_func, input logic [6:0] ev_note);
        int         active;
        int         rel;
        int         hit;
        logic [9:0] fnum;
        logic [2:0] block;
        begin
            active = (int'(voice_limit) > VOICES) ? VOICES : int'(voice_limit);
            hit = -1;
            if (ev_note >= NOTE_BASE && ev_note <= NOTE_TOP)
            begin
                rel = int'(ev_note) - int'(NOTE_BASE);
                if (ev_func == FUNC_ON)
                begin
                    for (int i = 0; i < active; i++)
                        if (hit < 0 && voice_note[i] == 7'd0)
                            hit = i;
                    if (hit >= 0)
                    begin
                        fnum  = FNUM_OF_SEMI[4'(rel % int'(SEMIS))];
                        block = 3'(rel / int'(SEMIS));
                        writes_due.push_back(chip_write(hit, ADDR_FNUM_LO + 8'(hit % 9),
                                                        fnum[7:0], 1'b0));
                        writes_due.push_back(chip_write(hit, ADDR_KEY + 8'(hit % 9),
                            KEY_ON_BIT | {3'b000, block, 2'b00} | {6'd0, fnum[9:8]}, 1'b1));
                        voice_note[hit] = ev_note;
                    end
                end
                else
                begin
                    for (int i = 0; i < active; i++)
                        if (hit < 0 && voice_note[i] == ev_note)
                            hit = i;
                    if (hit >= 0)
                    begin
                        writes_due.push_back(chip_write(hit, ADDR_KEY + 8'(hit % 9),
                                                        KEY_OFF_DATA, 1'b1));
                        voice_note[hit] = 7'd0;
                    end
                end
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        begin
            if (want != got)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VOICES; i++)
                voice_note[i] = 7'd0;
            voice_limit = VC_RESET;
            writes_due.delete();
            mismatch_count = 0;
        end
        else
        begin
            // retire a write before predicting, the next event cannot answer this cycle
            if (out_valid && !out_stall)
            begin
                if (writes_due.size() == 0)
                begin
                    $error("unpredicted write: addr 0x%0h data 0x%0h voice %0d",
                           reg_addr, reg_data, voice);
                    mismatch_count++;
                end
                else
                begin
                    seen = writes_due.pop_front();
                    check_field("reg_bank", int'(seen.bank), int'(reg_bank));
                    check_field("reg_addr", int'(seen.addr), int'(reg_addr));
                    check_field("reg_data", int'(seen.data), int'(reg_data));
                    check_field("voice", int'(seen.voice), int'(voice));
                    check_field("last", int'(seen.last), int'(last));
                end
            end
            if (cfg_we)
                voice_limit = cfg_wdata;
            if (in_valid && !in_stall)
                play_event(func, note);
        end
        writes_pending = writes_due.size();
    end

endmodule

// ----- test/note_voice_allocator_tb.sv -----
`timescale 1ns / 1ps
// note_voice_allocator_tb: event stimulus, output back-pressure, watchdog and verdict
// depends on nva_pkg, note_voice_allocator and nva_write_checker
module note_voice_allocator_tb;
    import nva_pkg::*;

    // in-range events that the random part sends, ignored ones not counted
    localparam int RANDOM_EVENTS = 1850;
    // quiet cycles before a voice count write: a scan that hits nothing gives no
    // transfer, so the block may still be busy after the last expected write
    localparam int SETTLE_CYCLES = 32;
    // cycles without any transfer before the run is declared hung
    localparam int IDLE_LIMIT    = 3000;

    // how the write side applies back-pressure during one stretch
    typedef enum int {DRAIN_FREE, DRAIN_LIGHT, DRAIN_HEAVY} drain_mode_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [4:0]  cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic        func;
    logic [6:0]  note;
    logic        out_valid;
    logic        out_stall;
    logic        reg_bank;
    logic [7:0]  reg_addr;
    logic [7:0]  reg_data;
    logic [4:0]  voice;
    logic        last;

    int          mismatch_count;
    int          writes_pending;
    int          idle_cycles = 0;
    drain_mode_t drain_mode;

    // notes recently keyed on, the pool that note-offs are drawn from
    logic [6:0]  sounding [$];

    note_voice_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .note      (note),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .reg_bank  (reg_bank),
        .reg_addr  (reg_addr),
        .reg_data  (reg_data),
        .voice     (voice),
        .last      (last)
    );

    nva_write_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .note           (note),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .reg_bank       (reg_bank),
        .reg_addr       (reg_addr),
        .reg_data       (reg_data),
        .voice          (voice),
        .last           (last),
        .mismatch_count (mismatch_count),
        .writes_pending (writes_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // write-side back-pressure: stretches of random length, each with its own pattern
    initial
    begin
        int span;
        out_stall = 1'b0;
        forever
        begin
            drain_mode = drain_mode_t'($urandom_range(2));
            span = $urandom_range(256, 32);
            repeat (span)
            begin
                @(negedge clk);
                case (drain_mode)
                    DRAIN_FREE:  out_stall = 1'b0;
                    DRAIN_LIGHT: out_stall = ($urandom_range(3) == 0);
                    default:     out_stall = ($urandom_range(9) < 7);
                endcase
            end
        end
    end

    // hang detection: any transfer on either channel restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // present one event and hold it until the transfer; valid stays high between
    // back-to-back events since it is only ever set at the falling edge
    task automatic send_event(input logic ev_func, input logic [6:0] ev_note);
        begin
            @(negedge clk);
            in_valid = 1'b1;
            func     = ev_func;
            note     = ev_note;
            do
                @(posedge clk);
            while (in_stall);
            if (ev_func == FUNC_ON && ev_note >= NOTE_BASE && ev_note <= NOTE_TOP)
            begin
                sounding.push_back(ev_note);
                // a full table drops note-ons, so keep the pool from growing stale
                if (sounding.size() > 40)
                    void'(sounding.pop_front());
            end
        end
    endtask

    // drop valid for the number of cycles given
    task automatic hold_off(input int cycles);
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    // voice count may only change while the block is idle
    task automatic set_voice_count(input logic [4:0] count);
        begin
            hold_off(1);
            while (writes_pending != 0) @(negedge clk);
            repeat (SETTLE_CYCLES) @(negedge clk);
            cfg_we    = 1'b1;
            cfg_wdata = count;
            @(negedge clk);
            cfg_we    = 1'b0;
        end
    endtask

    initial
    begin
        int         counted;
        int         phase_len;
        int         burst;
        int         pick;
        int         idx;
        logic [4:0] count;
        logic       ev_func;
        logic [6:0] ev_note;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 5'd0;
        in_valid  = 1'b0;
        func      = FUNC_ON;
        note      = 7'd0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // reset count of eighteen voices, edges of the playable range
        send_event(FUNC_ON, NOTE_BASE);
        send_event(FUNC_ON, NOTE_TOP);
        send_event(FUNC_ON, NOTE_BASE - 7'd1);
        send_event(FUNC_ON, NOTE_TOP + 7'd1);
        send_event(FUNC_ON, 7'd0);
        send_event(FUNC_ON, 7'd127);
        send_event(FUNC_OFF, 7'd127);
        send_event(FUNC_OFF, 7'd0);
        // note-off of a note nobody holds, then of a held note
        send_event(FUNC_OFF, 7'd60);
        send_event(FUNC_OFF, NOTE_BASE);
        // same note on two voices, the off frees the lower one first
        send_event(FUNC_ON, 7'd60);
        send_event(FUNC_ON, 7'd60);
        send_event(FUNC_OFF, 7'd60);
        send_event(FUNC_OFF, NOTE_TOP);
        send_event(FUNC_OFF, 7'd60);

        // single voice: second note-on finds the table full
        set_voice_count(5'd1);
        send_event(FUNC_ON, 7'd40);
        send_event(FUNC_ON, 7'd41);
        send_event(FUNC_OFF, 7'd41);
        send_event(FUNC_OFF, 7'd40);

        // no voice at all, everything ignored
        set_voice_count(5'd0);
        send_event(FUNC_ON, 7'd50);
        send_event(FUNC_OFF, 7'd50);

        // count above the table size is clamped
        set_voice_count(5'd31);
        send_event(FUNC_ON, 7'd30);
        send_event(FUNC_ON, 7'd31);
        send_event(FUNC_ON, 7'd32);

        // shrinking hides voice 2 with its note still held
        set_voice_count(5'd2);
        send_event(FUNC_OFF, 7'd32);
        send_event(FUNC_ON, 7'd33);

        // growing back makes it reachable again
        set_voice_count(5'd18);
        send_event(FUNC_OFF, 7'd32);
        send_event(FUNC_OFF, 7'd30);
        send_event(FUNC_OFF, 7'd31);

        // random phases, each under its own voice count; mostly note-ons and
        // note-offs of sounding notes, the rest noise over the whole field range
        counted = 0;
        while (counted < RANDOM_EVENTS)
        begin
            pick = $urandom_range(9);
            case (pick)
                0:       count = 5'd0;
                1:       count = 5'd1;
                2:       count = 5'd2;
                3:       count = 5'd9;
                4:       count = 5'd10;
                5:       count = 5'd17;
                6:       count = 5'd18;
                7:       count = 5'd31;
                default: count = 5'($urandom_range(31));
            endcase
            set_voice_count(count);
            phase_len = (count == 5'd0) ? 12 : $urandom_range(220, 60);
            while (phase_len > 0)
            begin
                burst = $urandom_range(24, 1);
                repeat (burst)
                begin
                    pick = $urandom_range(99);
                    if (pick < 46)
                    begin
                        ev_func = FUNC_ON;
                        ev_note = 7'($urandom_range(NOTE_TOP, NOTE_BASE));
                    end
                    else if (pick < 88 && sounding.size() != 0)
                    begin
                        ev_func = FUNC_OFF;
                        idx     = $urandom_range(sounding.size() - 1);
                        ev_note = sounding[idx];
                        sounding.delete(idx);
                    end
                    else
                    begin
                        ev_func = 1'($urandom_range(1));
                        ev_note = 7'($urandom_range(127));
                    end
                    send_event(ev_func, ev_note);
                    phase_len--;
                    if (count != 5'd0 && ev_note >= NOTE_BASE && ev_note <= NOTE_TOP)
                        counted++;
                end
                // between bursts: straight on, a short gap, or a full drain
                pick = $urandom_range(9);
                if (pick == 9)
                begin
                    hold_off(1);
                    while (writes_pending != 0) @(negedge clk);
                end
                else if (pick >= 3)
                    hold_off($urandom_range(15, 1));
            end
        end

        hold_off(1);
        while (writes_pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && writes_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/nva_pkg.sv
rtl/nva_voice_table.sv
rtl/note_voice_allocator.sv
test/nva_write_checker.sv
test/note_voice_allocator_tb.sv
